@@ src/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg: shared constants for the Sobel edge magnitude block
// Register indexes, widths, reset values and the pixel kind codes.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

   localparam int FW_W = 11;
   localparam int FH_W = 12;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd1024;

   localparam int PIX_W = 24;
   localparam int CH_W  = 8;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PAD   = 1'b1;

endpackage

@@ src/sem_ram.sv @@
// ----------------------------------------------------------------------------
// sem_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ src/sem_sqrt.sv @@
// ----------------------------------------------------------------------------
// sem_sqrt: iterative rounded square root, saturated at 255
// One result bit per cycle, then a combinational rounding step.
// ----------------------------------------------------------------------------
module sem_sqrt
   import sem_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [17:0]     radicand,
   output logic            done,
   output logic [CH_W-1:0] root
);
   // radicand < 2^18, so root < 2^9
   logic [17:0] s_ff, s_in;
   logic [8:0]  n_ff, n_in;
   logic [3:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic [8:0]  t;
   logic [17:0] tsq;
   logic [18:0] nn;

   assign t   = n_ff | (9'd1 << k_ff);
   assign tsq = t * t;
   assign nn  = {10'd0, n_ff} * {10'd0, n_ff} + {10'd0, n_ff};

   always_comb begin
      s_in = s_ff; n_in = n_ff; k_in = k_ff; busy_in = busy_ff; done = 1'b0;
      if (start) begin
         s_in = radicand; n_in = '0; k_in = 4'd8; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (k_ff == 4'hF) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            if (tsq <= s_ff) n_in = t;
            k_in = k_ff - 4'd1;
         end
      end
   end

   always_comb begin
      logic [9:0] r;
      r = {1'b0, n_ff} + ((({1'b0, s_ff}) > nn) ? 10'd1 : 10'd0);
      root = (r > 10'd255) ? 8'hFF : r[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      s_ff <= s_in; n_ff <= n_in; k_ff <= k_in;
   end
endmodule

@@ src/sobel_edge_magnitude_rgb.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel edge magnitude on RGB pixels
// Sequence: an input beat is accepted in S_IDLE, then written to the line store and
// shifted into the window in S_READ; a beat that yields a result then goes through
// S_CALC (window sums), S_ROOT (nine-step square root in three parallel lanes) and
// S_SEND, which holds rsp_tvalid until rsp_tready; no new beat is taken until S_IDLE.
// Reset: synchronous; positions and window clear, frame 1024x1024.
// Line store contents are undefined after reset and are masked at edges.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: in_red[7:0], in_green[15:8], in_blue[23:16]
   input  logic [23:0]           req_tdata,
   // tuser: kind
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: edge_red[7:0], edge_green[15:8], edge_blue[23:16], frame_end[24], pad
   output logic [31:0]           rsp_tdata,
   // tlast: row_end
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT) + 1;
   localparam int AW = CW + 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_READ = 5'b00010, S_CALC = 5'b00100,
      S_ROOT = 5'b01000, S_SEND = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic [CW:0]     w_eff;   // 1..MAX_WIDTH
   logic [RW-1:0]   h_eff;

   always_comb begin
      if (fw_ff == '0) w_eff = (CW+1)'(1);
      else if ({20'd0, fw_ff} > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
      else w_eff = (CW+1)'(fw_ff);
      if (fh_ff == '0) h_eff = RW'(1);
      else if ({20'd0, fh_ff} > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(fh_ff);
   end

   logic [CW-1:0]   in_col_ff;
   logic [1:0]      in_row_ff;
   logic [CW-1:0]   out_col_ff;
   logic [RW-1:0]   out_row_ff;
   logic [PIX_W-1:0] px_ff;
   logic            emit_ff;
   logic [PIX_W-1:0] win_ff [3][3];

   // line store: top row in u_top, middle row in u_mid
   logic [PIX_W-1:0] top_q, mid_q;
   logic             wr_en;
   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top (
      .clock, .wr_en(wr_en), .wr_addr(in_col_ff), .wr_data(mid_q),
      .rd_en(state_ff == S_IDLE), .rd_addr(in_col_ff), .rd_data(top_q));
   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid (
      .clock, .wr_en(wr_en), .wr_addr(in_col_ff), .wr_data(px_ff),
      .rd_en(state_ff == S_IDLE), .rd_addr(in_col_ff), .rd_data(mid_q));
   assign wr_en = (state_ff == S_READ);

   wire acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);

   // sums of squared gradients per channel from the shifted window; the sqrt lanes
   // capture them at the end of S_CALC
   logic [17:0] sumsq [3];
   logic [2:0]  vr, vc;
   always_comb begin
      vr = {out_row_ff + 1 < h_eff, 1'b1, out_row_ff != '0};
      vc = {{1'b0, out_col_ff} + 1 < w_eff, 1'b1, out_col_ff != '0};
      for (int ch = 0; ch < 3; ch++) begin
         logic signed [11:0] gx, gy, p [3][3];
         logic [10:0] ax, ay;
         logic [21:0] ssq;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               p[r][c] = (vr[r] && vc[c]) ?
                         $signed({4'd0, win_ff[r][c][8*ch +: 8]}) : 12'sd0;
         gx = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) <<< 1) + p[2][2] - p[2][0];
         gy = p[2][0] - p[0][0] + ((p[2][1] - p[0][1]) <<< 1) + p[2][2] - p[0][2];
         ax = gx[11] ? 11'(-gx) : 11'(gx);
         ay = gy[11] ? 11'(-gy) : 11'(gy);
         ssq = {11'd0, ax} * {11'd0, ax} + {11'd0, ay} * {11'd0, ay};
         // anything at or above 2^18 is far past the 255 saturation point
         sumsq[ch] = (ssq[21:18] != 4'd0) ? 18'h3FFFF : ssq[17:0];
      end
   end

   logic [2:0]  sdone;
   logic [CH_W-1:0] root [3];
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      sem_sqrt u_sqrt (.clock, .reset, .start(state_ff == S_CALC),
                       .radicand(sumsq[ch]), .done(sdone[ch]), .root(root[ch]));
   end

   logic row_end, frame_end;
   assign row_end   = {1'b0, out_col_ff} + 1 >= w_eff;
   assign frame_end = row_end && (out_row_ff + 1 >= h_eff);

   logic [23:0] res_ff;
   logic        rl_ff, fe_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (acc) state_in = S_READ;
         S_READ: state_in = emit_ff ? S_CALC : S_IDLE;
         S_CALC: state_in = S_ROOT;
         S_ROOT: if (&sdone) state_in = S_SEND;
         S_SEND: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fw_ff <= FRAME_WIDTH_RST; fh_ff <= FRAME_HEIGHT_RST;
         in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FRAME_WIDTH) fw_ff <= csr_data[FW_W-1:0];
            if (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT) begin
               in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
            end
            if (csr_index == REG_FRAME_HEIGHT) fh_ff <= csr_data[FH_W-1:0];
         end
         if (acc) begin
            px_ff   <= (req_tuser == KIND_PIXEL) ? req_tdata : '0;
            emit_ff <= in_row_ff >= 2 || (in_row_ff == 1 && in_col_ff != '0);
         end
         if (state_ff == S_READ) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1]; win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= top_q; win_ff[1][2] <= mid_q; win_ff[2][2] <= px_ff;
            if ({1'b0, in_col_ff} + 1 >= w_eff) begin
               in_col_ff <= '0;
               if (in_row_ff < 2) in_row_ff <= in_row_ff + 2'd1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (state_ff == S_CALC) begin
            rl_ff <= row_end; fe_ff <= frame_end;
            if (frame_end) begin
               in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
            end else if (row_end) begin
               out_col_ff <= '0; out_row_ff <= out_row_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
      if (state_ff == S_ROOT && (&sdone)) res_ff <= {root[2], root[1], root[0]};
   end

   assign rsp_tvalid = (state_ff == S_SEND);
   assign rsp_tdata  = {7'd0, fe_ff, res_ff};
   assign rsp_tlast  = rl_ff;
endmodule

@@ src/sem_checker.sv @@
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge block
// Handshake and framing properties seen on the top-level ports.
// ----------------------------------------------------------------------------
module sem_checker
   import sem_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped while stalled");
   a_fe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> rsp_tlast)
      else $error("frame end without row end");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready && !csr_ready)
      else $error("input taken while result pending");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("two items back to back");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast, .csr_valid, .csr_ready);
